@@ rtl/core/isort_pkg.sv @@
// Shared types and constants for the insertion sorter.
package isort_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] data_t;

  // Batch sequencer states
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast value in sorted position
    logic shift;   // move every entry one place toward cell 0
  } cell_ctrl_t;

endpackage

@@ rtl/core/isort_in_if.sv @@
// Input request channel: one value per request, with end-of-batch mark.
interface isort_in_if
  import isort_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

@@ rtl/core/isort_out_if.sv @@
// Output request channel: sorted values with final and dropped flags.
interface isort_out_if
  import isort_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  final_res;
  logic  dropped;

  modport source (output valid, output sorted_value, output final_res, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input dropped,
                  output ready);
endinterface

@@ rtl/core/isort_cell.sv @@
// One compare-and-shift cell of the sorting chain.
module isort_cell
  import isort_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  data_t      new_value,
  // neighbor below (toward cell 0)
  input  logic       prev_gt,
  input  logic       prev_valid,
  input  data_t      prev_value,
  // neighbor above
  input  logic       next_valid,
  input  data_t      next_value,
  output logic       gt,
  output logic       valid,
  output data_t      value
);

  logic take_prev;
  logic take_new;

  // Strict compare keeps equal values in arrival order
  assign gt        = valid && (value > new_value);
  assign take_prev = prev_gt;
  assign take_new  = !prev_gt && (gt || !valid);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.insert) begin
      valid <= valid | prev_valid;
    end
  end

  // Stored entry
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= next_value;
    end else if (ctrl.insert) begin
      if (take_prev) begin
        value <= prev_value;
      end else if (take_new) begin
        value <= new_value;
      end
    end
  end

endmodule

@@ rtl/core/insertion_sorter.sv @@
// Insertion sorter top level: cell chain, batch sequencer and output register.
//
//   channel | dir | payload                             | ends batch
//   din     | in  | value, last                         | last = 1
//   dout    | out | sorted_value, final_res, dropped    | final_res = 1
//
// Fill: one value per cycle; each cell compares against the broadcast value and
// shifts up in the same cycle, so values may arrive back to back.
// Drain: after the last request, stored values leave one per cycle from cell 0 as
// the chain shifts down while dout accepts; din.ready is low during the drain.
// A stalled dout holds the drain; the next batch is taken while the final result waits.
// Synchronous reset empties the chain; no clearing pass is needed.
module insertion_sorter
  import isort_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic         clk,
  input logic         rst,
  isort_in_if.sink    din,
  isort_out_if.source dout
);

  state_t                state;
  state_t                state_next;
  cell_ctrl_t            ctrl;
  logic                  in_accept;
  logic                  full;
  logic                  load;
  logic                  overflow;
  logic                  overflow_next;
  logic                  out_valid;
  logic                  out_valid_next;
  data_t                 out_value;
  logic                  out_final;
  logic                  out_dropped;
  logic [CAPACITY-1:0]   gt_vec;
  logic [CAPACITY-1:0]   valid_vec;
  logic [CAPACITY-1:0]   therm_chk;
  data_t                 val_arr [CAPACITY];

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  p_gt;
    logic  p_valid;
    data_t p_value;
    logic  n_valid;
    data_t n_value;

    if (i == 0) begin : g_bottom
      assign p_gt    = 1'b0;
      assign p_valid = 1'b1;
      assign p_value = '0;
    end else begin : g_mid_lo
      assign p_gt    = gt_vec[i-1];
      assign p_valid = valid_vec[i-1];
      assign p_value = val_arr[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_mid_hi
      assign n_valid = valid_vec[i+1];
      assign n_value = val_arr[i+1];
    end

    isort_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_value  (din.value),
      .prev_gt    (p_gt),
      .prev_valid (p_valid),
      .prev_value (p_value),
      .next_valid (n_valid),
      .next_value (n_value),
      .gt         (gt_vec[i]),
      .valid      (valid_vec[i]),
      .value      (val_arr[i])
    );
  end

  assign full      = valid_vec[CAPACITY-1];
  assign din.ready = (state == ST_FILL);
  assign in_accept = din.valid && din.ready;
  assign load      = (state == ST_DRAIN) && (!out_valid || dout.ready);

  // Sequencer next state and cell commands
  always_comb begin
    state_next    = state;
    ctrl.insert   = 1'b0;
    ctrl.shift    = 1'b0;
    overflow_next = overflow;
    case (state)
      ST_FILL: begin
        if (in_accept) begin
          ctrl.insert   = !full;
          overflow_next = overflow | full;
          if (din.last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load) begin
          ctrl.shift = 1'b1;
          if (!valid_vec[1]) begin
            state_next    = ST_FILL;
            overflow_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      overflow <= overflow_next;
    end
  end

  // Output register
  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (dout.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value   <= val_arr[0];
      out_final   <= !valid_vec[1];
      out_dropped <= overflow;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.sorted_value = out_value;
  assign dout.final_res    = out_final;
  assign dout.dropped      = out_dropped;

  // Occupied cells must form a contiguous run from cell 0
  assign therm_chk = valid_vec & (valid_vec + CAPACITY'(1));

  a_therm: assert property (@(posedge clk) disable iff (rst) therm_chk == '0)
    else $error("cell chain occupancy not contiguous");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> valid_vec[0])
    else $error("drain with empty chain");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    in_accept && din.last |=> state == ST_DRAIN)
    else $error("end of batch did not start drain");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    load && !valid_vec[1] |=> valid_vec == '0 && !overflow && state == ST_FILL)
    else $error("batch not cleared after final result");

endmodule
